>>> rtl/core/utf8_stream_validator_top_assert.svh
// Assertion macros for the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_TOP_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define U8VAL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8val assertion failed");
// Next-cycle implication, disabled during reset.
`define U8VAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8val assertion failed");
`else
`define U8VAL_ASSERT_SAME(label, clk, rst, ante, cons)
`define U8VAL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/u8val_pkg.sv
// Types and constants shared by the UTF-8 stream validator.
package u8val_pkg;

  localparam int CODE_W = 21;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NUL      = 3'd1,
    ERR_LEAD     = 3'd2,
    ERR_CONT     = 3'd3,
    ERR_OVERLONG = 3'd4,
    ERR_RANGE    = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_kind_t;

  // sequence length classes
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_TWO   = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR  = 2'd3;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;
  localparam logic [CODE_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CODE_W-1:0] SURR_HI  = 21'h00DFFF;

  // smallest code point each length class may encode
  localparam logic [CODE_W-1:0] CLASS_MIN [4] = '{
    21'h000000, 21'h000080, 21'h000800, 21'h010000
  };

endpackage

>>> rtl/core/u8val_if.sv
// Valid/ready channels for text bytes in and verdicts out.
interface u8val_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8val_out_if;
  logic       valid;
  logic       ready;
  logic       still_valid;
  logic [2:0] error_kind;
  logic       text_done;

  modport source (output valid, output still_valid, output error_kind, output text_done,
                  input ready);
  modport sink (input valid, input still_valid, input error_kind, input text_done,
                output ready);
endinterface

>>> rtl/core/utf8_stream_validator_top.sv
// Top level of the UTF-8 stream validator.
// Takes one text byte per beat and returns one verdict beat per byte: whether the
// text is still strict UTF-8 with no NUL, and the first error kind met. The verdict
// for a byte appears in the cycle after it is accepted, from a single output register.
// The block accepts a byte every cycle; byte_in.ready drops only while a finished
// verdict waits in that register and result_out.ready is low. Decoder state clears
// after the byte marked final_byte, so the next byte starts a new text.
`include "utf8_stream_validator_top_assert.svh"

module utf8_stream_validator_top (
  input  logic              clk,
  input  logic              rst,
  u8val_in_if.sink          byte_in,
  u8val_out_if.source       result_out
);

  logic [1:0]                      bytes_pending, pending_next;
  logic [u8val_pkg::CODE_W-1:0]    code_value, code_next;
  logic [1:0]                      sequence_class, class_next;
  logic                            error_seen, seen_next;
  u8val_pkg::err_kind_t            first_error, first_next;

  logic                            out_valid;
  logic                            out_still_valid;
  u8val_pkg::err_kind_t            out_kind;
  logic                            out_done;

  logic                            in_acc;
  logic                            hit;
  u8val_pkg::err_kind_t            hit_kind;
  logic [u8val_pkg::CODE_W-1:0]    cont_value;
  logic [1:0]                      pend_dec;
  logic                            res_valid;
  u8val_pkg::err_kind_t            res_kind;

  assign byte_in.ready = !out_valid || result_out.ready;
  assign in_acc        = byte_in.valid && byte_in.ready;

  assign cont_value = {code_value[u8val_pkg::CODE_W-7:0], byte_in.text_byte[5:0]};
  assign pend_dec   = bytes_pending - 2'd1;

  always_comb begin
    pending_next = bytes_pending;
    code_next    = code_value;
    class_next   = sequence_class;
    seen_next    = error_seen;
    first_next   = first_error;
    hit          = 1'b0;
    hit_kind     = u8val_pkg::ERR_NONE;
    if (!error_seen) begin
      if (bytes_pending == 2'd0) begin
        if (byte_in.text_byte == 8'h00) begin
          hit      = 1'b1;
          hit_kind = u8val_pkg::ERR_NUL;
        end else if (!byte_in.text_byte[7]) begin
          hit = 1'b0; // plain ASCII, nothing opens
        end else if (byte_in.text_byte >= u8val_pkg::LEAD2_LO &&
                     byte_in.text_byte <= u8val_pkg::LEAD2_HI) begin
          pending_next = 2'd1;
          class_next   = u8val_pkg::CLS_TWO;
          code_next    = {16'd0, byte_in.text_byte[4:0]};
        end else if (byte_in.text_byte >= u8val_pkg::LEAD3_LO &&
                     byte_in.text_byte <= u8val_pkg::LEAD3_HI) begin
          pending_next = 2'd2;
          class_next   = u8val_pkg::CLS_THREE;
          code_next    = {17'd0, byte_in.text_byte[3:0]};
        end else if (byte_in.text_byte >= u8val_pkg::LEAD4_LO &&
                     byte_in.text_byte <= u8val_pkg::LEAD4_HI) begin
          pending_next = 2'd3;
          class_next   = u8val_pkg::CLS_FOUR;
          code_next    = {18'd0, byte_in.text_byte[2:0]};
        end else begin
          hit      = 1'b1;
          hit_kind = u8val_pkg::ERR_LEAD;
        end
      end else if (byte_in.text_byte[7:6] != 2'b10) begin
        hit      = 1'b1;
        hit_kind = u8val_pkg::ERR_CONT;
      end else begin
        code_next    = cont_value;
        pending_next = pend_dec;
        // range checks once the last continuation is in
        if (pend_dec == 2'd0) begin
          if (cont_value < u8val_pkg::CLASS_MIN[sequence_class]) begin
            hit      = 1'b1;
            hit_kind = u8val_pkg::ERR_OVERLONG;
          end else if (cont_value > u8val_pkg::CODE_MAX ||
                       (cont_value >= u8val_pkg::SURR_LO &&
                        cont_value <= u8val_pkg::SURR_HI)) begin
            hit      = 1'b1;
            hit_kind = u8val_pkg::ERR_RANGE;
          end else begin
            code_next  = '0;
            class_next = u8val_pkg::CLS_NONE;
          end
        end
      end
      if (!hit && byte_in.final_byte && pending_next != 2'd0) begin
        hit      = 1'b1;
        hit_kind = u8val_pkg::ERR_TRUNC;
      end
      if (hit) begin
        seen_next    = 1'b1;
        first_next   = hit_kind;
        pending_next = 2'd0;
        code_next    = '0;
        class_next   = u8val_pkg::CLS_NONE;
      end
    end
    res_valid = !seen_next;
    res_kind  = seen_next ? first_next : u8val_pkg::ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending  <= 2'd0;
      code_value     <= '0;
      sequence_class <= u8val_pkg::CLS_NONE;
      error_seen     <= 1'b0;
      first_error    <= u8val_pkg::ERR_NONE;
    end else if (in_acc) begin
      if (byte_in.final_byte) begin
        bytes_pending  <= 2'd0;
        code_value     <= '0;
        sequence_class <= u8val_pkg::CLS_NONE;
        error_seen     <= 1'b0;
        first_error    <= u8val_pkg::ERR_NONE;
      end else begin
        bytes_pending  <= pending_next;
        code_value     <= code_next;
        sequence_class <= class_next;
        error_seen     <= seen_next;
        first_error    <= first_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_still_valid <= res_valid;
      out_kind        <= res_kind;
      out_done        <= byte_in.final_byte;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.still_valid = out_still_valid;
  assign result_out.error_kind  = out_kind;
  assign result_out.text_done   = out_done;

  // a clean verdict never carries an error kind
  `U8VAL_ASSERT_SAME(a_clean_no_kind, clk, rst, out_valid && out_still_valid, out_kind == u8val_pkg::ERR_NONE)
  // open sequence and its length class agree
  `U8VAL_ASSERT_SAME(a_class_match, clk, rst, 1'b1, (bytes_pending == 2'd0) == (sequence_class == u8val_pkg::CLS_NONE))
  // last byte of a text leaves the decoder clear
  `U8VAL_ASSERT_NEXT(a_final_clears, clk, rst, in_acc && byte_in.final_byte, bytes_pending == 2'd0 && !error_seen)
  // an error stays until the text ends
  `U8VAL_ASSERT_NEXT(a_err_sticky, clk, rst, in_acc && error_seen && !byte_in.final_byte, error_seen && first_error == $past(first_error))

endmodule

>>> sim/tb.sv
// Self-checking testbench for the UTF-8 stream validator: directed, random text and noise runs.
module tb;

  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic                 ok;
    u8val_pkg::err_kind_t kind;
    logic                 done;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  u8val_in_if  byte_ch ();
  u8val_out_if verdict_ch ();

  utf8_stream_validator_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (verdict_ch)
  );

  always #5 clk = ~clk;

  // decoder state mirrored by the predictor
  logic [1:0]                   dec_pending   = '0;
  logic [u8val_pkg::CODE_W-1:0] dec_code      = '0;
  logic [1:0]                   dec_class     = u8val_pkg::CLS_NONE;
  logic                         dec_err_seen  = 1'b0;
  u8val_pkg::err_kind_t         dec_first_err = u8val_pkg::ERR_NONE;

  verdict_t   pending_verdicts [$];
  logic [7:0] text_bytes [$];

  int  bytes_sent = 0;
  int  verdicts_seen = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  sink_hold = 0;
  bit  src_idle = 1'b0;
  bit  sink_idle = 1'b0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at verdict %0d: %s got %0h expected %0h",
             verdicts_seen, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void flag_error(input u8val_pkg::err_kind_t kind);
    if (!dec_err_seen) begin
      dec_err_seen  = 1'b1;
      dec_first_err = kind;
    end
    dec_pending = '0;
    dec_code    = '0;
    dec_class   = u8val_pkg::CLS_NONE;
  endfunction

  // Advance the mirrored decoder by one byte and queue the verdict it yields.
  function automatic void predict_verdict(input logic [7:0] b, input logic last);
    verdict_t v;
    if (!dec_err_seen) begin
      if (dec_pending == 2'd0) begin
        if (b == 8'h00) flag_error(u8val_pkg::ERR_NUL);
        else if (b < 8'h80) ;
        else if (b >= u8val_pkg::LEAD2_LO && b <= u8val_pkg::LEAD2_HI) begin
          dec_pending = 2'd1; dec_class = u8val_pkg::CLS_TWO;
          dec_code = u8val_pkg::CODE_W'(b[4:0]);
        end else if (b >= u8val_pkg::LEAD3_LO && b <= u8val_pkg::LEAD3_HI) begin
          dec_pending = 2'd2; dec_class = u8val_pkg::CLS_THREE;
          dec_code = u8val_pkg::CODE_W'(b[3:0]);
        end else if (b >= u8val_pkg::LEAD4_LO && b <= u8val_pkg::LEAD4_HI) begin
          dec_pending = 2'd3; dec_class = u8val_pkg::CLS_FOUR;
          dec_code = u8val_pkg::CODE_W'(b[2:0]);
        end else flag_error(u8val_pkg::ERR_LEAD);
      end else if (b[7:6] != 2'b10) begin
        flag_error(u8val_pkg::ERR_CONT);
      end else begin
        dec_code    = {dec_code[u8val_pkg::CODE_W-7:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 2'd0) begin
          if (dec_code < u8val_pkg::CLASS_MIN[dec_class])
            flag_error(u8val_pkg::ERR_OVERLONG);
          else if (dec_code > u8val_pkg::CODE_MAX ||
                   (dec_code >= u8val_pkg::SURR_LO && dec_code <= u8val_pkg::SURR_HI))
            flag_error(u8val_pkg::ERR_RANGE);
          else begin
            dec_code  = '0;
            dec_class = u8val_pkg::CLS_NONE;
          end
        end
      end
      // open sequence at end of text, only if this byte was clean
      if (last && !dec_err_seen && dec_pending != 2'd0) flag_error(u8val_pkg::ERR_TRUNC);
    end
    v.ok   = !dec_err_seen;
    v.kind = dec_err_seen ? dec_first_err : u8val_pkg::ERR_NONE;
    v.done = last;
    pending_verdicts = {pending_verdicts, v};
    if (last) begin
      dec_pending   = '0;
      dec_code      = '0;
      dec_class     = u8val_pkg::CLS_NONE;
      dec_err_seen  = 1'b0;
      dec_first_err = u8val_pkg::ERR_NONE;
    end
  endfunction

  function automatic void push_char(input logic [u8val_pkg::CODE_W-1:0] cp, input int len);
    case (len)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void push_valid_char(input int len);
    logic [u8val_pkg::CODE_W-1:0] cp;
    bit at_bound;
    at_bound = ($urandom_range(0, 4) == 0);
    case (len)
      1: if (at_bound) cp = $urandom_range(0, 1) ? 21'h01 : 21'h7F;
         else cp = u8val_pkg::CODE_W'($urandom_range(1, 'h7F));
      2: if (at_bound) cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
         else cp = u8val_pkg::CODE_W'($urandom_range('h80, 'h7FF));
      3: if (at_bound) begin
           case ($urandom_range(0, 3))
             0: cp = 21'h800;
             1: cp = 21'hD7FF;
             2: cp = 21'hE000;
             default: cp = 21'hFFFF;
           endcase
         end else begin
           cp = u8val_pkg::CODE_W'($urandom_range('h800, 'hFFFF));
           if (cp >= u8val_pkg::SURR_LO && cp <= u8val_pkg::SURR_HI) cp = cp ^ 21'h4000;
         end
      default: if (at_bound) cp = $urandom_range(0, 1) ? 21'h10000 : u8val_pkg::CODE_MAX;
               else cp = u8val_pkg::CODE_W'($urandom_range('h10000, 'h10FFFF));
    endcase
    push_char(cp, len);
  endfunction

  function automatic void push_faulty_char();
    logic [u8val_pkg::CODE_W-1:0] cp;
    logic [7:0] b;
    int len;
    int k;
    len = $urandom_range(2, 4);
    case ($urandom_range(0, 6))
      0: add_byte(8'h00);
      1: begin
        case ($urandom_range(0, 2))
          0: b = 8'($urandom_range('h80, 'hBF));
          1: b = 8'($urandom_range('hC0, 'hC1));
          default: b = 8'($urandom_range('hF5, 'hFF));
        endcase
        add_byte(b);
      end
      2: begin
        push_valid_char(len);
        k = $urandom_range(1, len - 1);
        b = 8'($urandom);
        case ($urandom_range(0, 2))
          0: b[7:6] = 2'b00;
          1: b[7:6] = 2'b01;
          default: b[7:6] = 2'b11;
        endcase
        text_bytes[text_bytes.size() - k] = b;
      end
      3: begin
        cp = u8val_pkg::CODE_W'($urandom_range(0, u8val_pkg::CLASS_MIN[len - 1] - 1));
        push_char(cp, len);
      end
      4: push_char(u8val_pkg::CODE_W'($urandom_range('hD800, 'hDFFF)), 3);
      5: push_char(u8val_pkg::CODE_W'($urandom_range('h110000, 'h13FFFF)), 4);
      default: begin
        push_valid_char(len);
        repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
      end
    endcase
  endfunction

  function automatic void build_text();
    int nchars;
    int fault_at;
    bit broken;
    text_bytes.delete();
    nchars   = $urandom_range(1, 8);
    broken   = ($urandom_range(0, 99) < 45);
    fault_at = $urandom_range(0, nchars - 1);
    for (int i = 0; i < nchars; i++) begin
      if (broken && i == fault_at) push_faulty_char();
      else push_valid_char($urandom_range(1, 4));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(src_idle);
    if (gap > 0) begin
      byte_ch.valid      <= 1'b0;
      byte_ch.text_byte  <= 8'($urandom);
      byte_ch.final_byte <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.text_byte  <= b;
    byte_ch.final_byte <= last;
    do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
    predict_verdict(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++)
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic wait_for_drain();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic test_directed();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    text_bytes = '{8'h7F, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};  // clean, max forms
    send_text();
    text_bytes = '{8'h00};                      // NUL lead
    send_text();
    text_bytes = '{8'hF5, 8'h41};               // bad lead, then sticky
    send_text();
    text_bytes = '{8'hC2, 8'h00};               // NUL as continuation on last beat
    send_text();
    text_bytes = '{8'hE0, 8'h80, 8'h80};        // overlong
    send_text();
    text_bytes = '{8'hED, 8'hA0, 8'h80};        // surrogate
    send_text();
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; // above max code point
    send_text();
    text_bytes = '{8'hE1, 8'h80};               // truncated
    send_text();
    text_bytes = '{8'h01};                      // one-byte text
    send_text();
  endtask

  task automatic test_back_to_back();
    int target;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    target    = bytes_sent + 150;
    while (bytes_sent < target) begin
      build_text();
      send_text();
    end
  endtask

  task automatic test_idle_texts();
    int target;
    int halfway;
    bit drained;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    drained   = 1'b0;
    target    = bytes_sent + 600;
    halfway   = bytes_sent + 300;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) {src_idle, sink_idle} = 2'($urandom_range(0, 3));
      build_text();
      send_text();
      if (!drained && bytes_sent >= halfway) begin
        wait_for_drain();
        drained = 1'b1;
      end
    end
  endtask

  task automatic test_noise();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (150) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      verdict_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      verdict_ch.ready <= 1'b0;
      sink_hold--;
    end else begin
      verdict_ch.ready <= 1'b1;
      sink_hold = pick_gap(sink_idle);
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict beat with nothing pending", 8'd1, 8'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_ch.still_valid !== want.ok)
          report_mismatch("still_valid", 8'(verdict_ch.still_valid), 8'(want.ok));
        if (verdict_ch.error_kind !== want.kind)
          report_mismatch("error_kind", 8'(verdict_ch.error_kind), 8'(want.kind));
        if (verdict_ch.text_done !== want.done)
          report_mismatch("text_done", 8'(verdict_ch.text_done), 8'(want.done));
      end
      verdicts_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL utf8_stream_validator_top");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.text_byte  = 8'h00;
    byte_ch.final_byte = 1'b0;
    verdict_ch.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_idle_texts();
    test_noise();

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("PASS utf8_stream_validator_top");
    else
      $display("FAIL utf8_stream_validator_top");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/u8val_pkg.sv
rtl/core/u8val_if.sv
rtl/core/utf8_stream_validator_top.sv
sim/tb.sv
